[rtl/core/srmq_pkg.sv]
// Package for the sparse-table range-minimum engine.
// Holds the fixed field widths, word kinds, parameter defaults and the length-to-level helper.
// No dependencies.
package srmq_pkg;

    localparam int DEF_MAX_LENGTH  = 1024;
    localparam int DEF_LEVELS      = 11;
    localparam int DEF_VALUE_WIDTH = 16;

    localparam int KIND_W      = 2;
    localparam int POS_W       = 10;
    localparam int LEN_FIELD_W = 11;
    localparam int DATA_W      = 16;

    localparam logic [LEN_FIELD_W-1:0] USED_LENGTH_RESET = 11'd1024;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_BUILD = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    typedef enum logic {
        REG_USED_LENGTH = 1'b0
    } reg_index_t;

    // Position of the leading one of a range length.
    function automatic logic [3:0] floor_log2(input logic [LEN_FIELD_W-1:0] x);
        logic [3:0] r;
        r = '0;
        for (int k = 1; k < LEN_FIELD_W; k++)
        begin
            if (x[k])
            begin
                r = 4'(k);
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/srmq_table.sv]
// Table memory of the range-minimum engine: one write port, two read ports.
// Each entry packs a position above a value; read data is registered.
// Depends on nothing but its parameters.
module srmq_table #(
    parameter int AW = 14,
    parameter int DW = 26
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_a_addr,
    input  logic [AW-1:0] rd_b_addr,
    output logic [DW-1:0] rd_a_data,
    output logic [DW-1:0] rd_b_data
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_data <= mem[rd_a_addr];
            rd_b_data <= mem[rd_b_addr];
        end
    end

endmodule

[rtl/core/srmq_engine.sv]
// Sequencer of the range-minimum engine: loads, the level-by-level build sweep,
// queries and the result register. Drives the ports of srmq_table.
// Depends on srmq_pkg.
module srmq_engine #(
    parameter int MAX_LENGTH  = srmq_pkg::DEF_MAX_LENGTH,
    parameter int LEVELS      = srmq_pkg::DEF_LEVELS,
    parameter int VALUE_WIDTH = srmq_pkg::DEF_VALUE_WIDTH,
    parameter int LEN_W       = $clog2(MAX_LENGTH + 1),
    parameter int AW          = $clog2(LEVELS) + $clog2(MAX_LENGTH),
    parameter int DW          = VALUE_WIDTH + $clog2(MAX_LENGTH)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [srmq_pkg::KIND_W-1:0]          in_kind,
    input  logic [srmq_pkg::POS_W-1:0]           in_left,
    input  logic [srmq_pkg::POS_W-1:0]           in_right,
    input  logic signed [srmq_pkg::DATA_W-1:0]   in_value,
    input  logic                                 cfg_write,
    input  logic [LEN_W-1:0]                     used_len,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [srmq_pkg::DATA_W-1:0]          out_value,
    output logic [srmq_pkg::POS_W-1:0]           out_pos,
    output logic                                 out_err,
    output logic                                 wr_en,
    output logic [AW-1:0]                        wr_addr,
    output logic [DW-1:0]                        wr_data,
    output logic                                 rd_en,
    output logic [AW-1:0]                        rd_a_addr,
    output logic [AW-1:0]                        rd_b_addr,
    input  logic [DW-1:0]                        rd_a_data,
    input  logic [DW-1:0]                        rd_b_data
);

    import srmq_pkg::*;

    localparam int IDX_W  = $clog2(MAX_LENGTH);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int LVLC_W = $clog2(LEVELS + 1);
    localparam int EW0    = (LEN_W > LEN_FIELD_W) ? LEN_W : LEN_FIELD_W;
    localparam int EW     = (EW0 > LEVELS + 1) ? EW0 : LEVELS + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLEVEL,
        S_BREAD,
        S_QADDR,
        S_QCMP
    } state_t;

    state_t                    state_reg, state_next;
    logic                      built_reg, built_next;
    logic [LVLC_W-1:0]         lvl_reg, lvl_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]          last_reg, last_next;
    logic                      wb_valid_reg, wb_valid_next;
    logic [AW-1:0]             wb_addr_reg, wb_addr_next;
    logic [POS_W-1:0]          left_reg, left_next;
    logic [POS_W-1:0]          right_reg, right_next;
    logic                      err_reg, err_next;
    logic                      out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]         out_value_reg, out_value_next;
    logic [POS_W-1:0]          out_pos_reg, out_pos_next;
    logic                      out_err_reg, out_err_next;

    logic [EW-1:0]             n_ext;
    logic [EW-1:0]             span;
    logic [EW-1:0]             half;
    logic                      load_go;
    logic signed [VALUE_WIDTH-1:0] load_fit;

    logic signed [VALUE_WIDTH-1:0] a_val, b_val;
    logic [IDX_W-1:0]          a_pos, b_pos;
    logic [DW-1:0]             wb_data;

    logic [LEN_FIELD_W-1:0]    q_len;
    logic [3:0]                q_lvl_raw;
    logic [3:0]                q_lvl;
    logic [LEN_FIELD_W-1:0]    q_second;
    logic                      q_err;

    assign n_ext    = EW'(used_len);
    assign span     = EW'(1) << lvl_reg;
    assign half     = span >> 1;
    assign load_fit = VALUE_WIDTH'(in_value);
    assign in_ready = (state_reg == S_IDLE);
    assign load_go  = in_ready && in_valid && (in_kind == KIND_LOAD)
                      && (EW'(in_left) < EW'(MAX_LENGTH));

    assign a_val = rd_a_data[VALUE_WIDTH-1:0];
    assign b_val = rd_b_data[VALUE_WIDTH-1:0];
    assign a_pos = rd_a_data[DW-1:VALUE_WIDTH];
    assign b_pos = rd_b_data[DW-1:VALUE_WIDTH];

    // Build merge: on a tie the right half supplies the entry.
    assign wb_data = (a_val < b_val) ? rd_a_data : rd_b_data;

    assign wr_en   = load_go || wb_valid_reg;
    assign wr_addr = wb_valid_reg ? wb_addr_reg : {LVL_W'(0), IDX_W'(in_left)};
    assign wr_data = wb_valid_reg ? wb_data : {IDX_W'(in_left), load_fit};

    // Query address generation from the registered range.
    assign q_len     = LEN_FIELD_W'(right_reg) - LEN_FIELD_W'(left_reg) + LEN_FIELD_W'(1);
    assign q_lvl_raw = floor_log2(q_len);
    assign q_lvl     = (int'(q_lvl_raw) > LEVELS - 1) ? 4'(LEVELS - 1) : q_lvl_raw;
    assign q_second  = LEN_FIELD_W'(right_reg) + LEN_FIELD_W'(1)
                       - (LEN_FIELD_W'(1) << q_lvl);
    assign q_err     = !built_reg || (left_reg > right_reg) || (EW'(right_reg) >= n_ext);

    always_comb
    begin
        state_next     = state_reg;
        built_next     = built_reg;
        lvl_next       = lvl_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        wb_valid_next  = 1'b0;
        wb_addr_next   = wb_addr_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_pos_next   = out_pos_reg;
        out_err_next   = out_err_reg;
        rd_en          = 1'b0;
        rd_a_addr      = '0;
        rd_b_addr      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_kind)
                        KIND_LOAD:
                        begin
                            if (load_go)
                            begin
                                built_next = 1'b0;
                            end
                        end
                        KIND_BUILD:
                        begin
                            lvl_next   = LVLC_W'(1);
                            state_next = S_BLEVEL;
                        end
                        KIND_QUERY:
                        begin
                            left_next  = in_left;
                            right_next = in_right;
                            state_next = S_QADDR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // Also the gap between levels, so the last entry of a
            // level is written before the next level reads it.
            S_BLEVEL:
            begin
                if ((lvl_reg < LVLC_W'(LEVELS)) && (span <= n_ext))
                begin
                    idx_next   = '0;
                    last_next  = IDX_W'(n_ext - span);
                    state_next = S_BREAD;
                end
                else
                begin
                    built_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_BREAD:
            begin
                rd_en         = 1'b1;
                rd_a_addr     = {LVL_W'(lvl_reg - LVLC_W'(1)), idx_reg};
                rd_b_addr     = {LVL_W'(lvl_reg - LVLC_W'(1)),
                                 IDX_W'(EW'(idx_reg) + half)};
                wb_valid_next = 1'b1;
                wb_addr_next  = {LVL_W'(lvl_reg), idx_reg};
                if (idx_reg == last_reg)
                begin
                    lvl_next   = lvl_reg + LVLC_W'(1);
                    state_next = S_BLEVEL;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_QADDR:
            begin
                rd_en      = !q_err;
                rd_a_addr  = {LVL_W'(q_lvl), IDX_W'(left_reg)};
                rd_b_addr  = {LVL_W'(q_lvl), IDX_W'(q_second)};
                err_next   = q_err;
                state_next = S_QCMP;
            end
            S_QCMP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_err_next   = err_reg;
                    if (err_reg)
                    begin
                        out_value_next = '0;
                        out_pos_next   = '0;
                    end
                    else if (a_val <= b_val)
                    begin
                        out_value_next = DATA_W'(a_val);
                        out_pos_next   = POS_W'(a_pos);
                    end
                    else
                    begin
                        out_value_next = DATA_W'(b_val);
                        out_pos_next   = POS_W'(b_pos);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            built_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            built_reg     <= 1'b0;
            lvl_reg       <= '0;
            idx_reg       <= '0;
            last_reg      <= '0;
            wb_valid_reg  <= 1'b0;
            wb_addr_reg   <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_pos_reg   <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            built_reg     <= built_next;
            lvl_reg       <= lvl_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            wb_valid_reg  <= wb_valid_next;
            wb_addr_reg   <= wb_addr_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_pos_reg   <= out_pos_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_pos   = out_pos_reg;
    assign out_err   = out_err_reg;

endmodule

[rtl/core/sparse_table_range_minimum.sv]
// Top level of the sparse-table range-minimum engine: configuration register,
// stream packing, and the table memory with its sequencer.
// Depends on srmq_pkg, srmq_table and srmq_engine.
//
// Usage. Words enter on the s_ side; s_tuser carries the kind (load, build,
// query). A load writes one signed value into level 0. A build sweeps each
// higher level of the table whose blocks fit in the effective length, with
// one table write per cycle within a level and a gap between levels. A query
// reads two overlapping blocks from the two read ports of the table; its result
// word is formed in the S_QADDR and S_QCMP states and leaves on the m_ side from
// the output register, and the next word can be accepted once the result is
// registered. Loads, builds and unused kinds give no result word. The block
// works on one word at a time.
// The result sits in an output register, so a new word is accepted while a
// result waits for m_tready; only a second query stalls until it is taken.
// Reset clears the control state and sets used_length to 1024; the table
// contents are not cleared and need no clearing pass. A load or a write of
// used_length marks the table as not built; queries then report range_error
// until the next build. Write used_length only while the block is idle.
module sparse_table_range_minimum #(
    parameter int MAX_LENGTH  = srmq_pkg::DEF_MAX_LENGTH,
    parameter int LEVELS      = srmq_pkg::DEF_LEVELS,
    parameter int VALUE_WIDTH = srmq_pkg::DEF_VALUE_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // left_or_position[9:0], right_end[19:10],
                                   // load_value[35:20], zero fill above
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // min_value[15:0], min_position[25:16],
                                   // zero fill above
    output logic [0:0]  m_tuser    // range_error[0]
);

    import srmq_pkg::*;

    localparam int IDX_W = $clog2(MAX_LENGTH);
    localparam int LVL_W = $clog2(LEVELS);
    localparam int LEN_W = $clog2(MAX_LENGTH + 1);
    localparam int AW    = LVL_W + IDX_W;
    localparam int DW    = VALUE_WIDTH + IDX_W;
    localparam int CW    = (LEN_W > LEN_FIELD_W) ? LEN_W : LEN_FIELD_W;

    logic [LEN_FIELD_W-1:0] used_length_reg, used_length_next;
    logic                   cfg_write;
    logic [LEN_W-1:0]       eff_len;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [DW-1:0]          wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_a_addr, rd_b_addr;
    logic [DW-1:0]          rd_a_data, rd_b_data;

    logic [DATA_W-1:0]      res_value;
    logic [POS_W-1:0]       res_pos;
    logic                   res_err;

    // The register file has a single entry at offset zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_USED_LENGTH);

    always_comb
    begin
        used_length_next = used_length_reg;
        if (cfg_write)
        begin
            used_length_next = pwdata[LEN_FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_length_reg <= USED_LENGTH_RESET;
        end
        else
        begin
            used_length_reg <= used_length_next;
        end
    end

    assign prdata = (paddr[2] == REG_USED_LENGTH) ? 32'(used_length_reg) : 32'd0;

    // Lengths above the table size saturate to it.
    assign eff_len = (CW'(used_length_reg) > CW'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                               : LEN_W'(used_length_reg);

    srmq_table #(
        .AW (AW),
        .DW (DW)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    srmq_engine #(
        .MAX_LENGTH  (MAX_LENGTH),
        .LEVELS      (LEVELS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .LEN_W       (LEN_W),
        .AW          (AW),
        .DW          (DW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_left   (s_tdata[9:0]),
        .in_right  (s_tdata[19:10]),
        .in_value  (signed'(s_tdata[35:20])),
        .cfg_write (cfg_write),
        .used_len  (eff_len),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (res_value),
        .out_pos   (res_pos),
        .out_err   (res_err),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    assign m_tdata = {6'd0, res_pos, res_value};
    assign m_tuser = res_err;

endmodule

[tb/tb_sparse_table_range_minimum.sv]
// Self-checking testbench for the sparse-table range-minimum engine: loads, builds and queries
// are streamed in with random idling and every query result is checked against a local table.
// Depends on srmq_pkg and the sparse_table_range_minimum RTL.
module tb_sparse_table_range_minimum;
    timeunit 1ns;
    timeprecision 1ps;

    import srmq_pkg::*;

    localparam int MAX_LEN = DEF_MAX_LENGTH;
    localparam int LEVEL_COUNT = DEF_LEVELS;

    // Kind code that the block has no use for; such words are swallowed without a result.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Byte addresses on the configuration port. Only used_length exists; the spare
    // address is there to show that a write to it changes nothing.
    localparam logic [2:0] USED_LENGTH_ADDR = 3'(4 * REG_USED_LENGTH);
    localparam logic [2:0] SPARE_ADDR = 3'd4;

    // Random words after the directed part and the full-length fill.
    localparam int RANDOM_WORDS = 600;
    // A build at full length takes no word until it has written every level, so the
    // watchdog must not end the run during it.
    localparam int WATCHDOG_LIMIT = 50000;

    typedef struct {
        logic [1:0]         kind;
        logic [9:0]         left;
        logic [9:0]         right;
        logic signed [15:0] value;
    } rmq_word_t;

    typedef struct {
        logic signed [15:0] value;
        logic [9:0]         position;
        logic               range_error;
    } range_min_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // left_or_position[9:0], right_end[19:10],
                                 // load_value[35:20], zero fill above
    logic [1:0]  s_tuser = '0;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // min_value[15:0], min_position[25:16], zero fill above
    logic [0:0]  m_tuser;        // range_error[0]

    // Words waiting to be driven, and query results waiting to arrive.
    rmq_word_t  pending_words[$];
    range_min_t expected_minima[$];

    // Local copy of the sparse table and of the control state.
    logic signed [15:0] level_min [LEVEL_COUNT][MAX_LEN];
    logic [9:0]         level_pos [LEVEL_COUNT][MAX_LEN];
    bit                 table_ready = 1'b0;
    logic [10:0]        used_length_reg = USED_LENGTH_RESET;

    int words_queued = 0;
    int words_accepted = 0;
    int useful_words = 0;
    int mismatches = 0;
    int results_seen = 0;
    int quiet_cycles = 0;

    // Handshake flags passed from the sampling edge to the driving edge.
    bit word_taken = 1'b0;
    bit result_taken = 1'b0;
    int send_gap = 0;
    int send_quiet = 0;
    int recv_stall = 0;
    int recv_quiet = 0;
    rmq_word_t next_word;

    sparse_table_range_minimum i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Lengths above the table size act as the full table.
    function automatic int effective_len();
        return (used_length_reg > MAX_LEN) ? MAX_LEN : int'(used_length_reg);
    endfunction

    // Fill the levels above 0 over the elements in use. On equal halves the
    // position comes from the right half.
    task automatic rebuild_levels();
        int n;
        int span;
        int half;
        logic signed [15:0] a;
        logic signed [15:0] b;
        n = effective_len();
        for (int i = 0; i < n; i++)
        begin
            level_pos[0][i] = 10'(i);
        end
        for (int p = 1; p < LEVEL_COUNT; p++)
        begin
            span = 1 << p;
            half = span >> 1;
            if (span > n)
            begin
                break;
            end
            for (int i = 0; i + span <= n; i++)
            begin
                a = level_min[p-1][i];
                b = level_min[p-1][i+half];
                if (a < b)
                begin
                    level_min[p][i] = a;
                    level_pos[p][i] = level_pos[p-1][i];
                end
                else
                begin
                    level_min[p][i] = b;
                    level_pos[p][i] = level_pos[p-1][i+half];
                end
            end
        end
        table_ready = 1'b1;
    endtask

    // Two overlapping power-of-two blocks cover the range; on equal values the
    // left block wins.
    function automatic range_min_t lookup_minimum(int left, int right);
        range_min_t r;
        int n;
        int span_len;
        int lvl;
        int second;
        n = effective_len();
        r.value = '0;
        r.position = '0;
        r.range_error = 1'b1;
        if (table_ready && left <= right && right < n)
        begin
            span_len = right - left + 1;
            lvl = 0;
            while ((2 << lvl) <= span_len)
            begin
                lvl++;
            end
            if (lvl > LEVEL_COUNT - 1)
            begin
                lvl = LEVEL_COUNT - 1;
            end
            second = right + 1 - (1 << lvl);
            if (level_min[lvl][left] <= level_min[lvl][second])
            begin
                r.value = level_min[lvl][left];
                r.position = level_pos[lvl][left];
            end
            else
            begin
                r.value = level_min[lvl][second];
                r.position = level_pos[lvl][second];
            end
            r.range_error = 1'b0;
        end
        return r;
    endfunction

    // Apply one accepted word to the local table; a query adds one expected result.
    task automatic predict_word(logic [1:0] kind, logic [9:0] left, logic [9:0] right,
                                logic signed [15:0] value);
        case (kind)
            KIND_LOAD:
            begin
                level_min[0][left] = value;
                level_pos[0][left] = left;
                table_ready = 1'b0;
            end
            KIND_BUILD:
            begin
                rebuild_levels();
            end
            KIND_QUERY:
            begin
                expected_minima.insert(expected_minima.size(),
                                       lookup_minimum(int'(left), int'(right)));
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------

    // Most gaps are short, a few are long, and now and then a stretch of
    // words goes through with no gap at all.
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 45)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Input side: driver at the falling edge, sampling at the rising edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || word_taken))
        begin
            word_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                next_word = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {4'b0, next_word.value, next_word.right, next_word.left};
                s_tuser <= next_word.kind;
                send_gap = pick_gap(send_quiet);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            word_taken = 1'b1;
            words_accepted++;
            predict_word(s_tuser, s_tdata[9:0], s_tdata[19:10], s_tdata[35:20]);
        end
    end

    // ------------------------------------------------------------------
    // Result side: back-pressure at the falling edge, checking at the rising edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                recv_stall = pick_gap(recv_quiet);
            end
            else if (recv_stall == 0 && $urandom_range(0, 31) == 0)
            begin
                recv_stall = $urandom_range(1, 6);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        range_min_t want;
        logic signed [15:0] got_value;
        logic [9:0] got_pos;
        logic got_err;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_taken = 1'b1;
            results_seen++;
            got_value = m_tdata[15:0];
            got_pos = m_tdata[25:16];
            got_err = m_tuser[0];
            if (expected_minima.size() == 0)
            begin
                report_mismatch($sformatf(
                    "result %0d arrived with nothing expected: %0d @%0d err %0d",
                    results_seen, got_value, got_pos, got_err));
            end
            else
            begin
                want = expected_minima.pop_front();
                if (got_value !== want.value || got_pos !== want.position ||
                    got_err !== want.range_error)
                begin
                    report_mismatch($sformatf(
                        "result %0d: expected %0d @%0d err %0d, got %0d @%0d err %0d",
                        results_seen, want.value, want.position, want.range_error,
                        got_value, got_pos, got_err));
                end
            end
        end
    end

    // Ends a run that stops making progress, for instance a result that never comes.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Signed values: extremes, a narrow band that makes equal minima common, and
    // anything at all.
    function automatic logic signed [15:0] pick_value();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            case ($urandom_range(0, 3))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        if (r < 55)
        begin
            v = int'($urandom_range(0, 6)) - 3;
            return 16'(v);
        end
        return 16'($urandom);
    endfunction

    // Fields that a kind does not use are filled at random so that every bit moves.
    task automatic queue_word(logic [1:0] kind, int left, int right, logic signed [15:0] value);
        rmq_word_t w;
        w.kind = kind;
        w.left = 10'(left);
        w.right = 10'(right);
        w.value = value;
        pending_words.insert(pending_words.size(), w);
        words_queued++;
        if (kind != KIND_UNUSED)
        begin
            useful_words++;
        end
    endtask

    task automatic queue_load(int position, logic signed [15:0] value);
        queue_word(KIND_LOAD, position, int'($urandom_range(0, 1023)), value);
    endtask

    task automatic queue_build();
        queue_word(KIND_BUILD, int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)),
                   16'($urandom));
    endtask

    task automatic queue_query(int left, int right);
        queue_word(KIND_QUERY, left, right, 16'($urandom));
    endtask

    task automatic queue_noise();
        queue_word(KIND_UNUSED, int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)),
                   16'($urandom));
    endtask

    // A range inside the used length; short spans are favored half the time.
    task automatic queue_valid_query();
        int n;
        int l;
        int r;
        n = effective_len();
        if (n == 0)
        begin
            queue_query(int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)));
        end
        else
        begin
            l = $urandom_range(0, n - 1);
            if ($urandom_range(0, 1) == 0)
            begin
                r = $urandom_range(l, n - 1);
            end
            else
            begin
                r = l + int'($urandom_range(0, 7));
                if (r > n - 1)
                begin
                    r = n - 1;
                end
            end
            queue_query(l, r);
        end
    endtask

    // Either the ends are swapped or the right end lies beyond the used length.
    task automatic queue_bad_query();
        int n;
        int l;
        int r;
        n = effective_len();
        if (n < MAX_LEN && $urandom_range(0, 1) == 0)
        begin
            r = $urandom_range(n, 1023);
            l = $urandom_range(0, r);
        end
        else
        begin
            l = $urandom_range(1, 1023);
            r = $urandom_range(0, l - 1);
        end
        queue_query(l, r);
    endtask

    task automatic queue_random_load();
        int n;
        n = effective_len();
        if (n > 0 && $urandom_range(0, 9) < 7)
        begin
            queue_load(int'($urandom_range(0, n - 1)), pick_value());
        end
        else
        begin
            queue_load(int'($urandom_range(0, 1023)), pick_value());
        end
    endtask

    // Every phase ends with a query, so once its result is in the block has
    // finished any build before it and is idle.
    task automatic settle();
        while (words_accepted != words_queued || expected_minima.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == USED_LENGTH_ADDR)
        begin
            used_length_reg = data[10:0];
            table_ready = 1'b0;
        end
    endtask

    task automatic check_used_length_readback();
        logic [31:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= USED_LENGTH_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== {21'b0, used_length_reg})
        begin
            report_mismatch($sformatf("used_length read back as %0d, expected %0d",
                                      got, used_length_reg));
        end
    endtask

    // Bits above the register width are random and must be dropped.
    task automatic set_length(int len);
        apb_write(USED_LENGTH_ADDR, {21'($urandom), 11'(len)});
        check_used_length_readback();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin : sequence_main
        int random_start;
        int big_lengths;
        int len;
        int steps;
        int pick;
        big_lengths = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Straight out of reset: length 1024, nothing built, unused kind ignored.
        check_used_length_readback();
        queue_word(KIND_UNUSED, 1023, 1023, 16'shFFFF);
        queue_query(0, 0);
        settle();

        // Four distinct values including both extremes; a load after the build
        // would invalidate the table, and a query before the build must fail.
        set_length(4);
        queue_load(0, 16'sh8000);
        queue_load(1, 16'sh7FFF);
        queue_load(2, 16'sh0000);
        queue_load(3, 16'shFFFF);
        queue_query(0, 3);
        queue_build();
        queue_query(0, 3);
        queue_query(1, 3);
        queue_query(1, 1);
        queue_query(2, 1);
        queue_query(0, 4);
        settle();

        // All values equal: the build takes the right position on ties and the
        // query takes the left block.
        for (int i = 0; i < 4; i++)
        begin
            queue_load(i, 16'sd5);
        end
        queue_build();
        queue_query(0, 3);
        queue_query(0, 2);
        settle();

        // A write to an address with no register leaves the table built.
        apb_write(SPARE_ADDR, $urandom);
        check_used_length_readback();
        queue_query(1, 2);
        settle();

        // Zero length: the build touches nothing and every query fails.
        set_length(0);
        queue_build();
        queue_query(0, 0);
        settle();

        // Fill the whole table once; from here on every build reads only loaded
        // elements, whatever the length.
        set_length(MAX_LEN);
        for (int i = 0; i < MAX_LEN; i++)
        begin
            queue_load(i, pick_value());
        end
        queue_build();
        queue_query(0, 1023);
        queue_query(1023, 1023);
        queue_query(0, 0);
        queue_query(1023, 0);
        queue_query(512, 1023);
        repeat (30) queue_valid_query();
        settle();

        // The largest register value saturates to the table size.
        set_length(2047);
        queue_build();
        queue_query(0, 1023);
        queue_query(1023, 1023);
        repeat (10) queue_valid_query();
        settle();

        // Random phases: a new length, some loads, a build, then mostly queries
        // with loads, rebuilds and ignored words mixed in. Full-length builds are
        // slow, so only a few phases use them.
        random_start = useful_words;
        while (useful_words < random_start + RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                len = 0;
            end
            else if (pick < 8 && big_lengths < 3)
            begin
                len = ($urandom_range(0, 1) == 0) ? MAX_LEN : int'($urandom_range(1025, 2047));
                big_lengths++;
            end
            else if (pick < 20)
            begin
                len = $urandom_range(41, 200);
            end
            else
            begin
                len = $urandom_range(1, 40);
            end
            set_length(len);

            repeat ($urandom_range(0, 6)) queue_random_load();
            queue_build();
            steps = $urandom_range(4, 24);
            repeat (steps)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    queue_valid_query();
                end
                else if (pick < 80)
                begin
                    queue_bad_query();
                end
                else if (pick < 86)
                begin
                    queue_random_load();
                end
                else if (pick < 90)
                begin
                    queue_noise();
                end
                else if (pick < 96)
                begin
                    queue_build();
                end
                else
                begin
                    queue_valid_query();
                end
            end
            queue_valid_query();
            settle();
        end

        settle();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && expected_minima.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
